### rtl/sap_pkg.sv
`default_nettype none

package sap_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AmtW  = 8;

  // Prefetch offsets seen when the PC is read as an operand
  localparam logic [DataW-1:0] PcOffNormal   = DataW'(8);
  localparam logic [DataW-1:0] PcOffRegShift = DataW'(12);

  localparam logic [3:0] RegPc = 4'hF;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } alu_op_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_kind_t;

  typedef struct packed {
    logic [3:0]       opcode;
    logic             immediate_operand;
    logic             set_flags;
    logic [11:0]      operand_field;
    logic             rn_is_pc;
    logic             rd_is_pc;
    logic [DataW-1:0] first_value;
    logic [DataW-1:0] second_value;
    logic [AmtW-1:0]  shift_reg_value;
    logic             carry_in;
    logic             overflow_in;
  } cmd_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             write_result;
    logic             flags_update;
    logic             restore_status;
    logic             flag_n;
    logic             flag_z;
    logic             flag_c;
    logic             flag_v;
  } res_t;

  // Decoded shift request handed to the shifter
  typedef struct packed {
    logic [DataW-1:0] value;
    shift_kind_t      kind;
    logic [AmtW-1:0]  amount;
    logic             rrx;
    logic             cin;
  } shift_req_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             carry;
  } shift_res_t;

endpackage

`default_nettype wire

### rtl/sap_shifter.sv
`default_nettype none

module sap_shifter
  import sap_pkg::*;
(
  input  shift_req_t req,
  output shift_res_t res
);

  logic [4:0]         amt5;
  logic               big;
  logic               is32;
  logic [DataW:0]     lsl_ext;
  logic [DataW:0]     lsr_ext;
  logic [DataW:0]     asr_ext;
  logic [2*DataW-1:0] ror_ext;
  logic [DataW-1:0]   ror_val;

  assign amt5 = req.amount[4:0];
  assign big  = (req.amount[AmtW-1:5] != '0);
  assign is32 = (req.amount == AmtW'(DataW));

  // Barrel shifts with one extra bit to catch the last bit shifted out
  assign lsl_ext = {1'b0, req.value} << amt5;
  assign lsr_ext = {req.value, 1'b0} >> amt5;
  assign asr_ext = $unsigned($signed({req.value, 1'b0}) >>> amt5);
  assign ror_ext = {req.value, req.value} >> amt5;
  assign ror_val = ror_ext[DataW-1:0];

  always_comb begin
    res.value = req.value;
    res.carry = req.cin;
    if (req.rrx) begin
      res.value = {req.cin, req.value[DataW-1:1]};
      res.carry = req.value[0];
    end else if (req.amount != '0) begin
      case (req.kind)
        SH_LSL: begin
          if (big) begin
            res.value = '0;
            res.carry = is32 ? req.value[0] : 1'b0;
          end else begin
            res.value = lsl_ext[DataW-1:0];
            res.carry = lsl_ext[DataW];
          end
        end
        SH_LSR: begin
          if (big) begin
            res.value = '0;
            res.carry = is32 ? req.value[DataW-1] : 1'b0;
          end else begin
            res.value = lsr_ext[DataW:1];
            res.carry = lsr_ext[0];
          end
        end
        SH_ASR: begin
          if (big) begin
            res.value = {DataW{req.value[DataW-1]}};
            res.carry = req.value[DataW-1];
          end else begin
            res.value = asr_ext[DataW:1];
            res.carry = asr_ext[0];
          end
        end
        SH_ROR: begin
          // top bit of the rotated word is the last bit moved round
          res.value = ror_val;
          res.carry = ror_val[DataW-1];
        end
        default: begin
          res.value = req.value;
          res.carry = req.cin;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/shifter_alu_data_processing.sv
`default_nettype none

// Data-processing execute unit: one 32-bit ALU instruction (AND .. MVN) with
// a rotated-immediate or shifted-register second operand and N/Z/C/V flags.
// Three register stages: operand decode and PC offset, barrel shift, then
// ALU and flags into the output register. A new instruction is taken every
// cycle unless cmd_stall is high; each result passes from the stage 1 and
// stage 2 registers into the output register, where it waits while
// res_stall holds it. A stall holds the pipe and lets bubbles close up.

module shifter_alu_data_processing
  import sap_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res
);

  // Stage 1 registers: decoded operands
  logic             v1;
  shift_req_t       s1_req;
  logic [DataW-1:0] s1_a;
  logic [3:0]       s1_op;
  logic             s1_s;
  logic             s1_rd_pc;
  logic             s1_vin;

  // Stage 2 registers: shifted operand
  logic             v2;
  logic [DataW-1:0] s2_a;
  logic [DataW-1:0] s2_b;
  logic             s2_sc;
  logic [3:0]       s2_op;
  logic             s2_s;
  logic             s2_rd_pc;
  logic             s2_cin;
  logic             s2_vin;

  logic en1, en2, en3;

  // Advance enables: a stage moves when empty or when the next one moves
  assign en3       = !res_valid || !res_stall;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign cmd_stall = !en1;

  // Decode
  logic             regshift;
  logic [DataW-1:0] pcoff;
  logic [4:0]       imm_amt;
  shift_kind_t      fld_kind;
  shift_req_t       req_next;
  logic [DataW-1:0] a_next;

  assign regshift = !cmd.immediate_operand && cmd.operand_field[4];
  assign pcoff    = regshift ? PcOffRegShift : PcOffNormal;
  assign imm_amt  = cmd.operand_field[11:7];
  assign fld_kind = shift_kind_t'(cmd.operand_field[6:5]);
  assign a_next   = cmd.rn_is_pc ? cmd.first_value + pcoff : cmd.first_value;

  always_comb begin
    req_next.cin = cmd.carry_in;
    req_next.rrx = 1'b0;
    if (cmd.immediate_operand) begin
      // imm8 rotated right by twice the rotate field
      req_next.value  = {{(DataW-8){1'b0}}, cmd.operand_field[7:0]};
      req_next.kind   = SH_ROR;
      req_next.amount = {{(AmtW-5){1'b0}}, cmd.operand_field[11:8], 1'b0};
    end else begin
      req_next.value  = (cmd.operand_field[3:0] == RegPc) ?
                        cmd.second_value + pcoff : cmd.second_value;
      req_next.kind   = fld_kind;
      if (regshift) begin
        req_next.amount = cmd.shift_reg_value;
      end else if (imm_amt == '0 && (fld_kind == SH_LSR || fld_kind == SH_ASR)) begin
        req_next.amount = AmtW'(DataW);
      end else begin
        req_next.amount = {{(AmtW-5){1'b0}}, imm_amt};
        req_next.rrx    = (imm_amt == '0) && (fld_kind == SH_ROR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= cmd_valid;
    end
    if (en1 && cmd_valid) begin
      s1_req   <= req_next;
      s1_a     <= a_next;
      s1_op    <= cmd.opcode;
      s1_s     <= cmd.set_flags;
      s1_rd_pc <= cmd.rd_is_pc;
      s1_vin   <= cmd.overflow_in;
    end
  end

  // Barrel shift
  shift_res_t sh_res;

  sap_shifter u_shifter (
    .req (s1_req),
    .res (sh_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2 && v1) begin
      s2_a     <= s1_a;
      s2_b     <= sh_res.value;
      s2_sc    <= sh_res.carry;
      s2_op    <= s1_op;
      s2_s     <= s1_s;
      s2_rd_pc <= s1_rd_pc;
      s2_cin   <= s1_req.cin;
      s2_vin   <= s1_vin;
    end
  end

  // ALU and flags
  logic [DataW-1:0] x, y, r;
  logic             ac;
  logic             logical;
  logic [DataW:0]   sum;
  res_t             res_next;

  always_comb begin
    logical = 1'b1;
    x       = s2_a;
    y       = s2_b;
    ac      = 1'b0;
    r       = '0;
    case (alu_op_t'(s2_op))
      OP_AND, OP_TST: r = s2_a & s2_b;
      OP_EOR, OP_TEQ: r = s2_a ^ s2_b;
      OP_ORR:         r = s2_a | s2_b;
      OP_MOV:         r = s2_b;
      OP_BIC:         r = s2_a & ~s2_b;
      OP_MVN:         r = ~s2_b;
      OP_SUB, OP_CMP: begin
        logical = 1'b0; y = ~s2_b; ac = 1'b1;
      end
      OP_RSB: begin
        logical = 1'b0; x = s2_b; y = ~s2_a; ac = 1'b1;
      end
      OP_ADD, OP_CMN: begin
        logical = 1'b0;
      end
      OP_ADC: begin
        logical = 1'b0; ac = s2_cin;
      end
      OP_SBC: begin
        logical = 1'b0; y = ~s2_b; ac = s2_cin;
      end
      OP_RSC: begin
        logical = 1'b0; x = s2_b; y = ~s2_a; ac = s2_cin;
      end
      default: r = '0;
    endcase
  end

  assign sum = {1'b0, x} + {1'b0, y} + {{DataW{1'b0}}, ac};

  always_comb begin
    res_next.result = logical ? r : sum[DataW-1:0];
    res_next.flag_c = logical ? s2_sc : sum[DataW];
    res_next.flag_v = logical ? s2_vin :
                      (~(x[DataW-1] ^ y[DataW-1]) & (x[DataW-1] ^ sum[DataW-1]));
    res_next.flag_n = res_next.result[DataW-1];
    res_next.flag_z = (res_next.result == '0);
    res_next.write_result = !(s2_op == OP_TST || s2_op == OP_TEQ ||
                              s2_op == OP_CMP || s2_op == OP_CMN);
    res_next.flags_update   = s2_s && !s2_rd_pc;
    res_next.restore_status = s2_s && s2_rd_pc;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en3) begin
      res_valid <= v2;
    end
    if (en3 && v2) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire
